@@ hdl/trqm_pkg.sv @@
// ----------------------------------------------------------------------------
// trqm_pkg
// Shared opcodes, status codes and cell control type for the tagged ring queue.
// ----------------------------------------------------------------------------
package trqm_pkg;

    // Operation selector carried by each request beat.
    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_MARK = 2'd2
    } opcode_t;

    // Status returned with each response beat.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Commands broadcast from the control logic to every cell in the chain.
    typedef struct packed {
        logic push;
        logic pop;
        logic mark;
    } cell_ctl_t;

endpackage

@@ hdl/trqm_if.sv @@
// ----------------------------------------------------------------------------
// trqm request and response interfaces
// Valid/ready channels that carry the queue operations and their results.
// ----------------------------------------------------------------------------
interface trqm_req_if #(
    parameter int HANDLE_WIDTH = 32,
    parameter int OWNER_WIDTH  = 16
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [HANDLE_WIDTH-1:0]       packet_handle;
    logic signed [OWNER_WIDTH-1:0] owner_id;
    logic                          remove_mark_in;

    modport source (
        output valid, opcode, packet_handle, owner_id, remove_mark_in,
        input  ready
    );

    modport sink (
        input  valid, opcode, packet_handle, owner_id, remove_mark_in,
        output ready
    );
endinterface

interface trqm_rsp_if #(
    parameter int HANDLE_WIDTH = 32,
    parameter int OWNER_WIDTH  = 16
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [HANDLE_WIDTH-1:0]       out_handle;
    logic signed [OWNER_WIDTH-1:0] out_owner;
    logic                          out_remove_mark;

    modport source (
        output valid, status, out_handle, out_owner, out_remove_mark,
        input  ready
    );

    modport sink (
        input  valid, status, out_handle, out_owner, out_remove_mark,
        output ready
    );
endinterface

@@ hdl/trqm_cell.sv @@
// ----------------------------------------------------------------------------
// trqm_cell
// One queue entry of the cell chain: handle, owner, remove mark, occupied flag.
// ----------------------------------------------------------------------------
module trqm_cell #(
    parameter int HANDLE_WIDTH = 32,
    parameter int OWNER_WIDTH  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  trqm_pkg::cell_ctl_t           ctl,
    input  logic                          prev_occ,
    input  logic                          nxt_occ,
    input  logic [HANDLE_WIDTH-1:0]       nxt_handle,
    input  logic signed [OWNER_WIDTH-1:0] nxt_owner,
    input  logic                          nxt_mark,
    input  logic [HANDLE_WIDTH-1:0]       push_handle,
    input  logic signed [OWNER_WIDTH-1:0] push_owner,
    input  logic                          push_mark,
    input  logic signed [OWNER_WIDTH-1:0] key_owner,
    output logic                          occ,
    output logic [HANDLE_WIDTH-1:0]       handle,
    output logic signed [OWNER_WIDTH-1:0] owner,
    output logic                          mark
);
    import trqm_pkg::*;

    logic                          occ_reg;
    logic                          occ_next;
    logic [HANDLE_WIDTH-1:0]       handle_reg;
    logic [HANDLE_WIDTH-1:0]       handle_next;
    logic signed [OWNER_WIDTH-1:0] owner_reg;
    logic signed [OWNER_WIDTH-1:0] owner_next;
    logic                          mark_reg;
    logic                          mark_next;

    // A pop shifts every entry one cell toward the head. A push lands in the
    // first free cell, which is the free cell whose upstream neighbor is full.
    always_comb
    begin
        occ_next    = occ_reg;
        handle_next = handle_reg;
        owner_next  = owner_reg;
        mark_next   = mark_reg;
        if (ctl.pop)
        begin
            occ_next    = nxt_occ;
            handle_next = nxt_handle;
            owner_next  = nxt_owner;
            mark_next   = nxt_mark;
        end
        else if (ctl.push && !occ_reg && prev_occ)
        begin
            occ_next    = 1'b1;
            handle_next = push_handle;
            owner_next  = push_owner;
            mark_next   = push_mark;
        end
        else if (ctl.mark && occ_reg && (owner_reg == key_owner))
        begin
            mark_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        handle_reg <= handle_next;
        owner_reg  <= owner_next;
        mark_reg   <= mark_next;
    end

    assign occ    = occ_reg;
    assign handle = handle_reg;
    assign owner  = owner_reg;
    assign mark   = mark_reg;

endmodule

@@ hdl/tagged_ring_queue_with_mark_by_id.sv @@
// ----------------------------------------------------------------------------
// tagged_ring_queue_with_mark_by_id
// Fixed-depth queue of tagged packet handles with pop, push and mark-by-owner.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Contents per beat
//  --------+-----------+---------------------------------------------------
//  req     | in        | opcode, packet_handle, owner_id, remove_mark_in
//  rsp     | out       | status, out_handle, out_owner, out_remove_mark
//
// Every request beat is answered by one response beat, which is presented
// in the cycle after acceptance from a single output register.
// The block takes one request beat per cycle as long as the response side
// keeps up; the single response register sets that figure, so a stalled
// response holds off the next request until it has been taken.
// Reset (rst_n low, asynchronous) empties the queue at once; entry contents
// are not cleared, because a free entry is never read.
//
// The queue is a chain of DEPTH identical cells with cell 0 at the head.
// Occupied cells always form a contiguous run starting at cell 0, so the
// queue is empty when cell 0 is free and full when the last cell is in use.
// A pop reads cell 0 and every cell loads its downstream neighbor in the
// same cycle. A push is written into the first free cell. A mark compares
// the owner key in every cell in parallel and sets the remove mark where it
// matches in an occupied cell; a free cell is never marked.
// An unused opcode is accepted and answered with an ok status.
// ----------------------------------------------------------------------------
module tagged_ring_queue_with_mark_by_id #(
    parameter int DEPTH        = 64,
    parameter int HANDLE_WIDTH = 32,
    parameter int OWNER_WIDTH  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    trqm_req_if.sink   req,
    trqm_rsp_if.source rsp
);
    import trqm_pkg::*;

    // Per-cell views of the chain.
    logic                          cell_occ    [DEPTH];
    logic [HANDLE_WIDTH-1:0]       cell_handle [DEPTH];
    logic signed [OWNER_WIDTH-1:0] cell_owner  [DEPTH];
    logic                          cell_mark   [DEPTH];
    logic [DEPTH-1:0]              occ_vec;

    cell_ctl_t ctl;
    logic      req_accept;
    logic      empty;
    logic      full;

    // Response register.
    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;
    status_t                       status_reg;
    status_t                       status_next;
    logic [HANDLE_WIDTH-1:0]       out_handle_reg;
    logic [HANDLE_WIDTH-1:0]       out_handle_next;
    logic signed [OWNER_WIDTH-1:0] out_owner_reg;
    logic signed [OWNER_WIDTH-1:0] out_owner_next;
    logic                          out_mark_reg;
    logic                          out_mark_next;

    // A new request may enter whenever the response register is free or is
    // being emptied in this same cycle.
    assign req.ready  = !rsp_valid_reg || rsp.ready;
    assign req_accept = req.valid && req.ready;

    assign empty = !cell_occ[0];
    assign full  = cell_occ[DEPTH-1];

    // Decode the accepted beat into cell commands and the response contents.
    // Failed pops and pushes return the default payload: zero handle, owner
    // of all ones, clear remove mark.
    always_comb
    begin
        ctl             = '0;
        status_next     = ST_OK;
        out_handle_next = '0;
        out_owner_next  = '1;
        out_mark_next   = 1'b0;
        unique case (opcode_t'(req.opcode))
            OP_PUSH:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctl.push = req_accept;
                end
            end
            OP_POP:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    ctl.pop         = req_accept;
                    out_handle_next = cell_handle[0];
                    out_owner_next  = cell_owner[0];
                    out_mark_next   = cell_mark[0];
                end
            end
            OP_MARK:
            begin
                ctl.mark = req_accept;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (req_accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            status_reg     <= status_next;
            out_handle_reg <= out_handle_next;
            out_owner_reg  <= out_owner_next;
            out_mark_reg   <= out_mark_next;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.out_handle      = out_handle_reg;
    assign rsp.out_owner       = out_owner_reg;
    assign rsp.out_remove_mark = out_mark_reg;

    // The cell chain. Cell i takes its shift data from cell i+1; the last
    // cell shifts in an empty entry. Cell 0 always sees a full neighbor on
    // its upstream side so that a push into an empty queue lands there.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                          prev_occ;
        logic                          nxt_occ;
        logic [HANDLE_WIDTH-1:0]       nxt_handle;
        logic signed [OWNER_WIDTH-1:0] nxt_owner;
        logic                          nxt_mark;

        if (i == 0)
        begin : g_head
            assign prev_occ = 1'b1;
        end
        else
        begin : g_body
            assign prev_occ = cell_occ[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign nxt_occ    = 1'b0;
            assign nxt_handle = '0;
            assign nxt_owner  = '1;
            assign nxt_mark   = 1'b0;
        end
        else
        begin : g_link
            assign nxt_occ    = cell_occ[i+1];
            assign nxt_handle = cell_handle[i+1];
            assign nxt_owner  = cell_owner[i+1];
            assign nxt_mark   = cell_mark[i+1];
        end

        trqm_cell #(
            .HANDLE_WIDTH (HANDLE_WIDTH),
            .OWNER_WIDTH  (OWNER_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .prev_occ    (prev_occ),
            .nxt_occ     (nxt_occ),
            .nxt_handle  (nxt_handle),
            .nxt_owner   (nxt_owner),
            .nxt_mark    (nxt_mark),
            .push_handle (req.packet_handle),
            .push_owner  (req.owner_id),
            .push_mark   (req.remove_mark_in),
            .key_owner   (req.owner_id),
            .occ         (cell_occ[i]),
            .handle      (cell_handle[i]),
            .owner       (cell_owner[i]),
            .mark        (cell_mark[i])
        );

        assign occ_vec[i] = cell_occ[i];
    end

`ifndef NO_ASSERTIONS
    // Occupied cells must stay a contiguous run from the head.
    a_occ_contiguous: assert property (
        @(posedge clk) disable iff (!rst_n)
        ((occ_vec >> 1) & ~occ_vec) == '0
    ) else $error("occupied cells are not contiguous from the head");

    // A pop on an empty queue must be reported as such.
    a_pop_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_accept && req.opcode == OP_POP && empty) |=> (status_reg == ST_EMPTY)
    ) else $error("pop on empty queue not flagged");

    // A push that is not dropped adds exactly one entry.
    a_push_grows: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_accept && req.opcode == OP_PUSH && !full)
            |=> ($countones(occ_vec) == $past($countones(occ_vec)) + 1)
    ) else $error("push did not add one entry");

    // A pop that succeeds removes exactly one entry.
    a_pop_shrinks: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_accept && req.opcode == OP_POP && !empty)
            |=> ($countones(occ_vec) + 1 == $past($countones(occ_vec)))
    ) else $error("pop did not remove one entry");

    // A failed operation returns the default payload.
    a_fail_default: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg != ST_OK)
            |-> (out_handle_reg == '0 && out_owner_reg == '1 && !out_mark_reg)
    ) else $error("failed operation returned a non-default payload");
`endif

endmodule
